// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication property under reset
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication property under reset
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/bsm_pkg.sv =====
// shared constants and types for the bounding sphere merge block
package bsm_pkg;
  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int SepW   = 17;
  localparam int SqW    = 68;
  localparam int DistW  = 35;
  localparam int ProdW  = 69;
  localparam int QuotW  = 64;

  typedef enum logic [1:0] {
    KIND_FIRST    = 2'd0,
    KIND_OLD_HOLD = 2'd1,
    KIND_NEW_HOLD = 2'd2,
    KIND_ENLARGE  = 2'd3
  } kind_e;

  localparam logic [1:0] ADDR_MIN_SEP = 2'd0;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;
endpackage

// ===== rtl/bsm_mul.sv =====
// bit-serial multiplier: one multiplier bit per cycle, shift and add
module bsm_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bsm_pkg::ProdW-1:0]    a_i,
  input  logic [bsm_pkg::DistW-1:0]    b_i,
  output logic                         done_o,
  output logic [bsm_pkg::ProdW+1:0]    p_o
);
  import bsm_pkg::*;

  logic [ProdW+1:0] acc_q, acc_d;
  logic [ProdW+1:0] mc_q, mc_d;
  logic [DistW-1:0] mp_q, mp_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q; mc_d = mc_q; mp_d = mp_q; cnt_d = cnt_q; run_d = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; mc_d = {2'b00, a_i}; mp_d = b_i; cnt_d = '0; run_d = 1'b1;
    end else if (run_q) begin
      if (mp_q[0]) acc_d = acc_q + mc_q;
      mc_d = mc_q << 1;
      mp_d = mp_q >> 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DistW - 1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mc_q <= mc_d; mp_q <= mp_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== rtl/bounding_sphere_merge.sv =====
// top level: running bounding sphere of a stream of spheres
//
// input channel: one sphere per request (centre x/y/z, radius), valid/ready
// output channel: one merged sphere per request plus merge_kind, valid/ready
// config: apb-style port, register 0 is min_separation (17 bits, reset 1)
//
// one request is worked at a time. the first sphere is copied into the
// bound and passes through S_OUT into the output register. every later
// request runs the bit-serial multiplier four times (three axis squares
// and the square of the radius difference); a containment result goes
// from S_DEC through S_OUT into the output register. an enlarging merge
// adds a bit-by-bit square root; with the centres within min_separation
// the new centre is taken as it is, otherwise each axis adds a serial
// product, a restoring division of the 69-bit product and an update
// state. the serial multiplier and the divider set the rate.
//
// the result sits in an output register; while the receiver stalls the
// block holds it and takes no new request. the next request can be taken
// the cycle after the result leaves. reset empties the bound (the next
// sphere is copied in) and sets min_separation to 1.
module bounding_sphere_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sphere_valid_i,
  output logic                          sphere_ready_o,
  input  logic signed [31:0]            sphere_x_i,
  input  logic signed [31:0]            sphere_y_i,
  input  logic signed [31:0]            sphere_z_i,
  input  logic [30:0]                   sphere_radius_i,
  output logic                          bound_valid_o,
  input  logic                          bound_ready_i,
  output logic signed [31:0]            bound_x_o,
  output logic signed [31:0]            bound_y_o,
  output logic signed [31:0]            bound_z_o,
  output logic [30:0]                   bound_radius_o,
  output logic [1:0]                    merge_kind_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bsm_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;  // squaring one axis
  localparam logic [3:0] S_DR    = 4'd2;  // squaring radius difference
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_KSET  = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;  // |delta| * k
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_AXEND = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] st_q, st_d;

  // configuration
  logic [SepW-1:0] sep_q, sep_d;
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == ADDR_MIN_SEP[0:0]) ? {15'd0, sep_q} : 32'd0;
  always_comb begin
    sep_d = sep_q;
    if (psel && penable && pwrite && paddr[2:2] == ADDR_MIN_SEP[0:0])
      sep_d = pwdata[SepW-1:0];
  end

  // state of the bound
  logic                     have_q, have_d;
  logic signed [31:0]       cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [30:0]              rad_q, rad_d;
  // captured request
  logic signed [31:0]       nx_q, nx_d, ny_q, ny_d, nz_q, nz_d;
  logic [30:0]              nr_q, nr_d;
  // working registers
  logic [1:0]               ax_q, ax_d;
  logic [SqW-1:0]           s_q, s_d;
  logic [SqW-1:0]           drsq_q, drsq_d;
  logic [DistW-1:0]         dist_q, dist_d;
  logic [5:0]               bit_q, bit_d;
  logic [SqW+1:0]           srem_q, srem_d;   // sqrt remainder
  logic [SqW-1:0]           sin_q, sin_d;     // sqrt radicand shifter
  logic [DistW-1:0]         k_q, k_d;
  logic [DistW+1:0]         big_d;
  logic [ProdW-1:0]         dv_q, dv_d;       // dividend shifter
  logic [DistW:0]           rem_q, rem_d;
  logic [6:0]               dcnt_q, dcnt_d;
  logic signed [31:0]       ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [30:0]              orad_q, orad_d;
  logic [1:0]               okind_q, okind_d;
  logic                     ovld_q, ovld_d;

  // serial multiplier
  logic              mstart;
  logic [ProdW-1:0]  ma;
  logic [DistW-1:0]  mb;
  logic              mdone;
  logic [ProdW+1:0]  mp;
  unit_ctl_t         mctl;

  bsm_mul u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(mstart), .a_i(ma), .b_i(mb),
    .done_o(mdone), .p_o(mp)
  );

  // per-axis delta old - new
  logic signed [32:0] dlt;
  logic signed [31:0] nsel;
  always_comb begin
    case (ax_q)
      2'd0:    begin dlt = 33'(cx_q) - 33'(nx_q); nsel = nx_q; end
      2'd1:    begin dlt = 33'(cy_q) - 33'(ny_q); nsel = ny_q; end
      default: begin dlt = 33'(cz_q) - 33'(nz_q); nsel = nz_q; end
    endcase
  end

  logic [30:0] dr;
  assign dr = (rad_q >= nr_q) ? rad_q - nr_q : nr_q - rad_q;

  // sqrt trial: remainder shifted in two bits, compare against 4*root+1
  logic [SqW+1:0] s_try;
  logic [SqW+1:0] s_tst;
  assign s_try = {srem_q[SqW-1:0], sin_q[SqW-1:SqW-2]};
  assign s_tst = {33'd0, dist_q, 2'b01};

  // division step
  logic [DistW+1:0] d_try;
  assign d_try = {rem_q, dv_q[ProdW-1]};

  logic signed [32:0] shifted;
  logic [ProdW-1:0]   quo;
  assign quo = dv_q;  // quotient bits shift into dividend register
  assign shifted = dlt[32] ? 33'(nsel) - 33'(quo[32:0]) : 33'(nsel) + 33'(quo[32:0]);

  assign mctl.start = mstart;
  assign mctl.busy  = (st_q == S_SQ) || (st_q == S_DR) || (st_q == S_PROD);

  always_comb begin
    st_d = st_q; have_d = have_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; rad_d = rad_q;
    nx_d = nx_q; ny_d = ny_q; nz_d = nz_q; nr_d = nr_q;
    ax_d = ax_q; s_d = s_q; drsq_d = drsq_q; dist_d = dist_q; bit_d = bit_q;
    srem_d = srem_q; sin_d = sin_q; k_d = k_q; big_d = '0;
    dv_d = dv_q; rem_d = rem_q; dcnt_d = dcnt_q;
    ox_d = ox_q; oy_d = oy_q; oz_d = oz_q; orad_d = orad_q; okind_d = okind_q;
    ovld_d = ovld_q;
    mstart = 1'b0; ma = '0; mb = '0;
    if (ovld_q && bound_ready_i) ovld_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (sphere_valid_i && !ovld_q) begin
          nx_d = sphere_x_i; ny_d = sphere_y_i; nz_d = sphere_z_i;
          nr_d = sphere_radius_i;
          if (!have_q) begin
            have_d = 1'b1;
            cx_d = sphere_x_i; cy_d = sphere_y_i; cz_d = sphere_z_i;
            rad_d = sphere_radius_i;
            okind_d = KIND_FIRST;
            st_d = S_OUT;
          end else begin
            ax_d = 2'd0; s_d = '0;
            st_d = S_SQ;
            mstart = 1'b1;
            ma = ProdW'(33'(cx_q) - 33'(sphere_x_i));
            if (ma[32]) ma = ProdW'(33'(-ma[32:0])); else ma = ProdW'(ma[32:0]);
            mb = DistW'(ma[32:0]);
          end
        end
      end
      S_SQ: begin
        if (mdone) begin
          s_d = s_q + mp[SqW-1:0];
          if (ax_q == 2'd2) begin
            st_d = S_DR; mstart = 1'b1;
            ma = ProdW'(dr); mb = DistW'(dr);
          end else begin
            ax_d = ax_q + 2'd1;
            mstart = 1'b1;
            case (ax_q)
              2'd0:    ma = ProdW'(33'(cy_q) - 33'(ny_q));
              default: ma = ProdW'(33'(cz_q) - 33'(nz_q));
            endcase
            if (ma[32]) ma = ProdW'(33'(-ma[32:0])); else ma = ProdW'(ma[32:0]);
            mb = DistW'(ma[32:0]);
          end
        end
      end
      S_DR: begin
        if (mdone) begin
          drsq_d = mp[SqW-1:0];
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        if (drsq_q >= s_q) begin
          if (rad_q < nr_q) begin
            cx_d = nx_q; cy_d = ny_q; cz_d = nz_q; rad_d = nr_q;
            okind_d = KIND_NEW_HOLD;
          end else begin
            okind_d = KIND_OLD_HOLD;
          end
          st_d = S_OUT;
        end else begin
          srem_d = '0; sin_d = s_q; dist_d = '0; bit_d = '0;
          st_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle
        sin_d = sin_q << 2;
        if (s_try >= s_tst) begin
          srem_d = s_try - s_tst;
          dist_d = {dist_q[DistW-2:0], 1'b1};
        end else begin
          srem_d = s_try;
          dist_d = {dist_q[DistW-2:0], 1'b0};
        end
        bit_d = bit_q + 6'd1;
        if (bit_q == 6'(DistW - 2)) st_d = S_KSET;
      end
      S_KSET: begin
        big_d = (DistW+2)'((37'(dist_q) + 37'(rad_q) + 37'(nr_q)) >> 1);
        if (37'(big_d) >= 37'(nr_q)) k_d = DistW'(big_d - (DistW+2)'(nr_q));
        else k_d = '0;
        okind_d = KIND_ENLARGE;
        orad_d = (big_d > (DistW+2)'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : big_d[30:0];
        if (dist_q > DistW'(sep_q) && dist_q != '0) begin
          ax_d = 2'd0; st_d = S_PROD; mstart = 1'b1;
          ma = ProdW'(33'(cx_q) - 33'(nx_q));
          if (ma[32]) ma = ProdW'(33'(-ma[32:0])); else ma = ProdW'(ma[32:0]);
          mb = k_d;
        end else begin
          cx_d = nx_q; cy_d = ny_q; cz_d = nz_q; rad_d = orad_d;
          st_d = S_OUT;
        end
      end
      S_PROD: begin
        if (mdone) begin
          dv_d = mp[ProdW-1:0]; rem_d = '0; dcnt_d = '0;
          st_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, quotient bits shifted into the dividend
        if (d_try >= (DistW+2)'(dist_q)) begin
          rem_d = (DistW+1)'(d_try - (DistW+2)'(dist_q));
          dv_d = {dv_q[ProdW-2:0], 1'b1};
        end else begin
          rem_d = d_try[DistW:0];
          dv_d = {dv_q[ProdW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 7'd1;
        if (dcnt_q == 7'(ProdW - 1)) st_d = S_AXEND;
      end
      S_AXEND: begin
        case (ax_q)
          2'd0:    ox_d = shifted[31:0];
          2'd1:    oy_d = shifted[31:0];
          default: oz_d = shifted[31:0];
        endcase
        if (ax_q == 2'd2) begin
          cx_d = ox_q; cy_d = oy_q; cz_d = shifted[31:0]; rad_d = orad_q;
          st_d = S_OUT;
        end else begin
          ax_d = ax_q + 2'd1; st_d = S_PROD; mstart = 1'b1;
          case (ax_q)
            2'd0:    ma = ProdW'(33'(cy_q) - 33'(ny_q));
            default: ma = ProdW'(33'(cz_q) - 33'(nz_q));
          endcase
          if (ma[32]) ma = ProdW'(33'(-ma[32:0])); else ma = ProdW'(ma[32:0]);
          mb = k_q;
        end
      end
      S_OUT: begin
        ox_d = cx_q; oy_d = cy_q; oz_d = cz_q; orad_d = rad_q;
        ovld_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; have_q <= 1'b0; sep_q <= SepW'(1); ovld_q <= 1'b0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0; rad_q <= '0;
    end else begin
      st_q <= st_d; have_q <= have_d; sep_q <= sep_d; ovld_q <= ovld_d;
      cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; rad_q <= rad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d; ny_q <= ny_d; nz_q <= nz_d; nr_q <= nr_d;
    ax_q <= ax_d; s_q <= s_d; drsq_q <= drsq_d; dist_q <= dist_d; bit_q <= bit_d;
    srem_q <= srem_d; sin_q <= sin_d; k_q <= k_d;
    dv_q <= dv_d; rem_q <= rem_d; dcnt_q <= dcnt_d;
    ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d; orad_q <= orad_d; okind_q <= okind_d;
  end

  // ready only when idle with an empty output register
  assign sphere_ready_o = (st_q == S_IDLE) && !ovld_q && !(mctl.busy && mctl.start);
  assign bound_valid_o  = ovld_q;
  assign bound_x_o      = ox_q;
  assign bound_y_o      = oy_q;
  assign bound_z_o      = oz_q;
  assign bound_radius_o = orad_q;
  assign merge_kind_o   = okind_q;
endmodule

// ===== rtl/bsm_checker.sv =====
// port-level checker for the bounding sphere merge block, with its bind
`include "assert_macros.svh"
module bsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        sphere_valid_i,
  input logic        sphere_ready_o,
  input logic        bound_valid_o,
  input logic        bound_ready_i,
  input logic [30:0] bound_radius_o,
  input logic [1:0]  merge_kind_o
);
  import bsm_pkg::*;
  `ASSERT_NEXT(a_req_then_no_ready, clk_i, rst_ni, sphere_valid_i && sphere_ready_o, !sphere_ready_o)
  `ASSERT_IMPL(a_no_ready_with_result, clk_i, rst_ni, bound_valid_o, !sphere_ready_o)
  `ASSERT_NEXT(a_result_holds, clk_i, rst_ni, bound_valid_o && !bound_ready_i, bound_valid_o && $stable(bound_radius_o))
  `ASSERT_NEXT(a_kind_holds, clk_i, rst_ni, bound_valid_o && !bound_ready_i, $stable(merge_kind_o))
endmodule

bind bounding_sphere_merge bsm_checker u_bsm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .sphere_valid_i(sphere_valid_i),
  .sphere_ready_o(sphere_ready_o), .bound_valid_o(bound_valid_o),
  .bound_ready_i(bound_ready_i), .bound_radius_o(bound_radius_o),
  .merge_kind_o(merge_kind_o)
);
